FILE: rtl/pfr_pkg.sv
package pfr_pkg;

    // Default sizes handed to the top level.
    localparam int MAX_FRAMES_DEF = 16;
    localparam int ADDR_BITS_DEF  = 16;
    localparam int PID_BITS_DEF   = 4;

    // Configuration port.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int CFG_W   = 5;

    localparam logic [1:0] REG_TOTAL_FRAMES = 2'd0;
    localparam logic [1:0] REG_FRAMES_PER_PROC = 2'd1;
    localparam logic [1:0] REG_POLICY = 2'd2;

    localparam logic [CFG_W-1:0] TOTAL_FRAMES_RST = 5'd16;
    localparam logic [CFG_W-1:0] FRAMES_PER_PROC_RST = 5'd4;
    localparam logic POLICY_RST = 1'b1;

    localparam logic POLICY_LIFO = 1'b0;
    localparam logic POLICY_MRU  = 1'b1;

    // Result outcome codes.
    localparam logic [2:0] OUT_DONE     = 3'd0;
    localparam logic [2:0] OUT_HIT      = 3'd1;
    localparam logic [2:0] OUT_LOADED   = 3'd2;
    localparam logic [2:0] OUT_REPLACED = 3'd3;
    localparam logic [2:0] OUT_UNSERVED = 3'd4;

    typedef struct packed {
        logic [CFG_W-1:0] total_frames;
        logic [CFG_W-1:0] frames_per_process;
        logic             policy;
    } cfg_t;

endpackage

FILE: rtl/pfr_frame_ram.sv
module pfr_frame_ram
    import pfr_pkg::*;
#(
    parameter int DEPTH = MAX_FRAMES_DEF,
    parameter int WIDTH = ADDR_BITS_DEF + PID_BITS_DEF,
    parameter int AW    = 4
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/pfr_cfg_regs.sv
module pfr_cfg_regs
    import pfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_sel;
    logic       wr_stb;

    assign reg_sel = paddr[3:2];
    assign wr_stb  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_frames       <= TOTAL_FRAMES_RST;
            cfg_reg.frames_per_process <= FRAMES_PER_PROC_RST;
            cfg_reg.policy             <= POLICY_RST;
        end
        else if (wr_stb)
        begin
            case (reg_sel)
                REG_TOTAL_FRAMES:    cfg_reg.total_frames <= pwdata[CFG_W-1:0];
                REG_FRAMES_PER_PROC: cfg_reg.frames_per_process <= pwdata[CFG_W-1:0];
                REG_POLICY:          cfg_reg.policy <= pwdata[0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_sel)
            REG_TOTAL_FRAMES:    prdata[CFG_W-1:0] = cfg_reg.total_frames;
            REG_FRAMES_PER_PROC: prdata[CFG_W-1:0] = cfg_reg.frames_per_process;
            REG_POLICY:          prdata[0] = cfg_reg.policy;
            default:             prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/page_frame_replacement.sv
// Page frame replacement engine with MRU and LIFO hit policies.
// A request (process_id, page_address, is_done_marker) is taken at the rising
// clock edge at which start is high and busy is low. busy then stays high
// until the single result has been shown. Each request yields exactly one
// result, presented on the result ports for one cycle with result_valid high;
// the receiver cannot stall, so the result is taken at the edge ending it.
// A done marker goes straight to the result state. A lookup walks the
// resident list held in one frame memory (one read port, one write port,
// registered read): it scans the resident entries, then, where needed,
// closes the gap left by a moved or evicted entry and appends the entry.
// The scan and the shift move one entry per cycle through the memory port.
// Configuration goes through the APB-style port: total_frames at 0x0,
// frames_per_process at 0x4 and policy at 0x8. The user is to write it
// only while the block is idle; the block itself does not enforce this.
// Reset empties the list, clears both counters and loads the register
// defaults (16 frames, 4 per process, MRU); no clearing pass is needed,
// since only entries below the resident count are ever read.
module page_frame_replacement
    import pfr_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int PID_BITS   = PID_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB-style configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    // Request channel
    input  logic                 start,
    output logic                 busy,
    input  logic [PID_BITS-1:0]  process_id,
    input  logic [ADDR_BITS-1:0] page_address,
    input  logic                 is_done_marker,
    // Result channel
    output logic                 result_valid,
    output logic [2:0]           outcome,
    output logic                 evicted_valid,
    output logic [ADDR_BITS-1:0] evicted_address,
    output logic [PID_BITS-1:0]  evicted_process,
    output logic [31:0]          fault_count,
    output logic [31:0]          replacement_count
);

    // Index into the frame memory, and a count that can hold MAX_FRAMES itself.
    localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int ENT_W = ADDR_BITS + PID_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_APPEND = 3'd4;
    localparam logic [2:0] S_RESULT = 3'd5;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    cfg_t cfg;

    pfr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Frame memory: each entry is {page address, owner process}.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ENT_W-1:0] mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [ENT_W-1:0] mem_rdata;

    pfr_frame_ram #(
        .DEPTH (MAX_FRAMES),
        .WIDTH (ENT_W),
        .AW    (IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    logic [ADDR_BITS-1:0] rd_addr_fld;
    logic [PID_BITS-1:0]  rd_pid_fld;

    assign rd_addr_fld = mem_rdata[ENT_W-1:PID_BITS];
    assign rd_pid_fld  = mem_rdata[PID_BITS-1:0];

    // Control registers (reset).
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             hit_reg, hit_next;
    logic [CNT_W-1:0] own_reg, own_next;
    logic             ev_valid_reg, ev_valid_next;
    logic [31:0]      faults_reg, faults_next;
    logic [31:0]      repl_reg, repl_next;

    // Request, scan capture and result payload (no reset).
    logic [PID_BITS-1:0]  req_pid_reg, req_pid_next;
    logic [ADDR_BITS-1:0] req_addr_reg, req_addr_next;
    logic [IDX_W-1:0]     rd_pos_reg, rd_pos_next;
    logic [IDX_W-1:0]     wr_pos_reg, wr_pos_next;
    logic [IDX_W-1:0]     hit_pos_reg, hit_pos_next;
    logic [PID_BITS-1:0]  hit_own_reg, hit_own_next;
    logic [ADDR_BITS-1:0] last_addr_reg, last_addr_next;
    logic [PID_BITS-1:0]  last_own_reg, last_own_next;
    logic [IDX_W-1:0]     vict_pos_reg, vict_pos_next;
    logic [ADDR_BITS-1:0] vict_addr_reg, vict_addr_next;
    logic [PID_BITS-1:0]  vict_own_reg, vict_own_next;
    logic [IDX_W-1:0]     app_pos_reg, app_pos_next;
    logic [ADDR_BITS-1:0] app_addr_reg, app_addr_next;
    logic [PID_BITS-1:0]  app_own_reg, app_own_next;
    logic [2:0]           outcome_reg, outcome_next;
    logic [ADDR_BITS-1:0] ev_addr_reg, ev_addr_next;
    logic [PID_BITS-1:0]  ev_pid_reg, ev_pid_next;

    logic [CNT_W-1:0] count_m1;
    logic [CNT_W-1:0] idx_m1;
    logic             proc_ok;
    logic             mem_ok;

    assign count_m1 = count_reg - CNT_W'(1);
    assign idx_m1   = idx_reg - CNT_W'(1);

    // The store is full once the resident count reaches the smaller of
    // total_frames and the memory depth; a lowered total_frames keeps the
    // entries already resident.
    assign mem_ok  = (CMP_W'(count_reg) < CMP_W'(cfg.total_frames))
                  && (CMP_W'(count_reg) < CMP_W'(MAX_FRAMES));
    assign proc_ok = CMP_W'(own_reg) < CMP_W'(cfg.frames_per_process);

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        rd_vld_next    = 1'b0;
        wr_pend_next   = 1'b0;
        hit_next       = hit_reg;
        own_next       = own_reg;
        ev_valid_next  = ev_valid_reg;
        faults_next    = faults_reg;
        repl_next      = repl_reg;
        req_pid_next   = req_pid_reg;
        req_addr_next  = req_addr_reg;
        rd_pos_next    = rd_pos_reg;
        wr_pos_next    = wr_pos_reg;
        hit_pos_next   = hit_pos_reg;
        hit_own_next   = hit_own_reg;
        last_addr_next = last_addr_reg;
        last_own_next  = last_own_reg;
        vict_pos_next  = vict_pos_reg;
        vict_addr_next = vict_addr_reg;
        vict_own_next  = vict_own_reg;
        app_pos_next   = app_pos_reg;
        app_addr_next  = app_addr_reg;
        app_own_next   = app_own_reg;
        outcome_next   = outcome_reg;
        ev_addr_next   = ev_addr_reg;
        ev_pid_next    = ev_pid_reg;
        mem_we         = 1'b0;
        mem_waddr      = app_pos_reg;
        mem_wdata      = {app_addr_reg, app_own_reg};
        mem_re         = 1'b0;
        mem_raddr      = idx_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_pid_next  = process_id;
                    req_addr_next = page_address;
                    idx_next      = '0;
                    hit_next      = 1'b0;
                    own_next      = '0;
                    outcome_next  = OUT_DONE;
                    ev_valid_next = 1'b0;
                    ev_addr_next  = '0;
                    ev_pid_next   = '0;
                    state_next    = is_done_marker ? S_RESULT : S_SCAN;
                end
            end

            S_SCAN:
            begin
                // One read issued per cycle; the entry read last cycle is compared now.
                if (idx_reg < count_reg)
                begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_pos_next = idx_reg[IDX_W-1:0];
                    idx_next    = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DECIDE;
                end
                if (rd_vld_reg)
                begin
                    if (rd_addr_fld == req_addr_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_pos_next = rd_pos_reg;
                        hit_own_next = rd_pid_fld;
                    end
                    if (rd_pid_fld == req_pid_reg)
                    begin
                        own_next       = own_reg + CNT_W'(1);
                        vict_pos_next  = rd_pos_reg;
                        vict_addr_next = rd_addr_fld;
                        vict_own_next  = rd_pid_fld;
                    end
                    if (CNT_W'(rd_pos_reg) == count_m1)
                    begin
                        last_addr_next = rd_addr_fld;
                        last_own_next  = rd_pid_fld;
                    end
                end
            end

            S_DECIDE:
            begin
                app_addr_next = req_addr_reg;
                app_own_next  = req_pid_reg;
                app_pos_next  = count_m1[IDX_W-1:0];
                if (hit_reg)
                begin
                    outcome_next = OUT_HIT;
                    if (cfg.policy == POLICY_MRU)
                    begin
                        app_own_next = hit_own_reg;
                        idx_next     = CNT_W'(hit_pos_reg) + CNT_W'(1);
                        state_next   = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    faults_next = sat_inc(faults_reg);
                    if (proc_ok && mem_ok)
                    begin
                        outcome_next = OUT_LOADED;
                        app_pos_next = count_reg[IDX_W-1:0];
                        count_next   = count_reg + CNT_W'(1);
                        state_next   = S_APPEND;
                    end
                    else
                    begin
                        repl_next = sat_inc(repl_reg);
                        if (proc_ok && (count_reg != '0))
                        begin
                            // Global store full: the newest entry goes.
                            outcome_next  = OUT_REPLACED;
                            ev_valid_next = 1'b1;
                            ev_addr_next  = last_addr_reg;
                            ev_pid_next   = last_own_reg;
                            idx_next      = count_reg;
                            state_next    = S_SHIFT;
                        end
                        else if (!proc_ok && (own_reg != '0))
                        begin
                            // Quota full: the newest entry of this process goes.
                            outcome_next  = OUT_REPLACED;
                            ev_valid_next = 1'b1;
                            ev_addr_next  = vict_addr_reg;
                            ev_pid_next   = vict_own_reg;
                            idx_next      = CNT_W'(vict_pos_reg) + CNT_W'(1);
                            state_next    = S_SHIFT;
                        end
                        else
                        begin
                            outcome_next = OUT_UNSERVED;
                            state_next   = S_RESULT;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // Entry k is read while entry k-2 is written with what came back,
                // so a read never meets a write to the same entry.
                if (wr_pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wr_pos_reg;
                    mem_wdata = mem_rdata;
                end
                if (idx_reg < count_reg)
                begin
                    mem_re       = 1'b1;
                    wr_pend_next = 1'b1;
                    wr_pos_next  = idx_m1[IDX_W-1:0];
                    idx_next     = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_APPEND;
                end
            end

            S_APPEND:
            begin
                mem_we     = 1'b1;
                state_next = S_RESULT;
            end

            S_RESULT:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            wr_pend_reg  <= 1'b0;
            hit_reg      <= 1'b0;
            own_reg      <= '0;
            ev_valid_reg <= 1'b0;
            faults_reg   <= '0;
            repl_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            wr_pend_reg  <= wr_pend_next;
            hit_reg      <= hit_next;
            own_reg      <= own_next;
            ev_valid_reg <= ev_valid_next;
            faults_reg   <= faults_next;
            repl_reg     <= repl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_pid_reg   <= req_pid_next;
        req_addr_reg  <= req_addr_next;
        rd_pos_reg    <= rd_pos_next;
        wr_pos_reg    <= wr_pos_next;
        hit_pos_reg   <= hit_pos_next;
        hit_own_reg   <= hit_own_next;
        last_addr_reg <= last_addr_next;
        last_own_reg  <= last_own_next;
        vict_pos_reg  <= vict_pos_next;
        vict_addr_reg <= vict_addr_next;
        vict_own_reg  <= vict_own_next;
        app_pos_reg   <= app_pos_next;
        app_addr_reg  <= app_addr_next;
        app_own_reg   <= app_own_next;
        outcome_reg   <= outcome_next;
        ev_addr_reg   <= ev_addr_next;
        ev_pid_reg    <= ev_pid_next;
    end

    assign result_valid      = (state_reg == S_RESULT);
    assign outcome           = outcome_reg;
    assign evicted_valid     = ev_valid_reg;
    assign evicted_address   = ev_addr_reg;
    assign evicted_process   = ev_pid_reg;
    assign fault_count       = faults_reg;
    assign replacement_count = repl_reg;

`ifndef ASSERT_OFF
    // The resident list never grows past the memory depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(count_reg) <= CMP_W'(MAX_FRAMES))
        else $error("resident count exceeds the frame memory depth");

    // After a result the block is ready for the next request.
    a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !busy)
        else $error("block still busy after presenting a result");

    // An eviction is only ever reported with a replacement.
    a_evict_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && evicted_valid) |-> (outcome == OUT_REPLACED))
        else $error("eviction reported without a replacement outcome");

    // Every replacement is also a fault, so the fault count leads.
    a_counter_order: assert property (@(posedge clk) disable iff (!rst_n)
        (repl_reg != $past(repl_reg)) |-> (faults_reg != $past(faults_reg))
            || (faults_reg == 32'hFFFF_FFFF))
        else $error("replacement counted without a fault");
`endif

endmodule

FILE: test/page_frame_replacement_tb.sv
module page_frame_replacement_tb
    import pfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES = MAX_FRAMES_DEF;
    localparam int ADDR_W = ADDR_BITS_DEF;
    localparam int PID_W  = PID_BITS_DEF;

    // The watchdog only counts cycles in which neither a request nor a result is
    // accepted, so this limit leaves a wide margin over the slowest request, the
    // longest sender gap and a drain pause in any correct run.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 64;
    localparam int POOL_SIZE      = 20;
    localparam int SEGMENTS       = 7;
    localparam int SEGMENT_ITEMS  = 150;
    localparam int RING_DEPTH     = 8;

    typedef struct packed {
        logic [PID_W-1:0]  pid;
        logic [ADDR_W-1:0] addr;
        logic              done;
    } page_req_t;

    typedef struct packed {
        logic [2:0]        outcome;
        logic              ev_valid;
        logic [ADDR_W-1:0] ev_addr;
        logic [PID_W-1:0]  ev_pid;
        logic [31:0]       faults;
        logic [31:0]       repls;
    } page_result_t;

    // One row of the directed part: an optional register write made while
    // the block is idle, then one request. Where typed is set, the result
    // is the one written in the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic         cfg_en;
        logic [1:0]   cfg_reg;
        logic [4:0]   cfg_val;
        page_req_t    req;
        logic         typed;
        page_result_t known;
    } directed_row_t;

    localparam page_result_t NO_RESULT = '0;
    localparam int N_DIRECTED = 22;

    localparam directed_row_t DIRECTED [N_DIRECTED] = '{
        // Done marker straight after reset: nothing changes, counters zero.
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'hF, 16'hFFFF, 1'b1},
          1'b1, '{OUT_DONE, 1'b0, 16'h0000, 4'h0, 32'd0, 32'd0}},
        // No frames at all and an empty list: the replacement is counted
        // but nothing can be loaded.
        '{1'b1, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h0000, 1'b0},
          1'b1, '{OUT_UNSERVED, 1'b0, 16'h0000, 4'h0, 32'd1, 32'd1}},
        // A frame count above the store size acts as the full store.
        '{1'b1, REG_TOTAL_FRAMES, 5'd31, '{4'h0, 16'h0000, 1'b0},
          1'b1, '{OUT_LOADED, 1'b0, 16'h0000, 4'h0, 32'd2, 32'd1}},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'hF, 16'hFFFF, 1'b0},
          1'b1, '{OUT_LOADED, 1'b0, 16'h0000, 4'h0, 32'd3, 32'd1}},
        // Hit on the oldest entry; under MRU it moves to the newest end.
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h0000, 1'b0},
          1'b1, '{OUT_HIT, 1'b0, 16'h0000, 4'h0, 32'd3, 32'd1}},
        // The lookup ignores the owner: another process hits this page.
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h3, 16'hFFFF, 1'b0}, 1'b0, NO_RESULT},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h0001, 1'b0}, 1'b0, NO_RESULT},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h0002, 1'b0}, 1'b0, NO_RESULT},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h0003, 1'b0}, 1'b0, NO_RESULT},
        // Process quota now full: its newest entry is evicted.
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h8000, 1'b0}, 1'b0, NO_RESULT},
        // LIFO: a hit leaves the order untouched.
        '{1'b1, REG_POLICY, {4'b0, POLICY_LIFO}, '{4'h0, 16'h0000, 1'b0},
          1'b0, NO_RESULT},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h7FFF, 1'b0}, 1'b0, NO_RESULT},
        // Zero quota and a process that owns nothing: unserved fault.
        '{1'b1, REG_FRAMES_PER_PROC, 5'd0, '{4'h7, 16'h1234, 1'b0}, 1'b0, NO_RESULT},
        // Zero quota, but this process owns an entry, which goes.
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'hF, 16'h5555, 1'b0}, 1'b0, NO_RESULT},
        '{1'b1, REG_FRAMES_PER_PROC, 5'd31, '{4'h9, 16'hABCD, 1'b1},
          1'b0, NO_RESULT},
        // Frame count lowered below the resident count: the list is kept
        // and every miss replaces the newest entry.
        '{1'b1, REG_TOTAL_FRAMES, 5'd3, '{4'h1, 16'h0AAA, 1'b0}, 1'b0, NO_RESULT},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h2, 16'h0BBB, 1'b0}, 1'b0, NO_RESULT},
        '{1'b1, REG_TOTAL_FRAMES, 5'd1, '{4'h2, 16'h0BBB, 1'b0}, 1'b0, NO_RESULT},
        '{1'b1, REG_POLICY, {4'b0, POLICY_MRU}, '{4'h5, 16'h00FF, 1'b0},
          1'b0, NO_RESULT},
        '{1'b1, REG_TOTAL_FRAMES, 5'd16, '{4'h5, 16'hFF00, 1'b0}, 1'b0, NO_RESULT},
        '{1'b1, REG_FRAMES_PER_PROC, 5'd16, '{4'h6, 16'hAAAA, 1'b0},
          1'b0, NO_RESULT},
        '{1'b0, REG_TOTAL_FRAMES, 5'd0, '{4'h0, 16'h0000, 1'b1}, 1'b0, NO_RESULT}
    };

    // Settings of the random segments, the extremes among them.
    localparam logic [4:0] SEG_TOTAL [SEGMENTS] = '{5'd16, 5'd5, 5'd16, 5'd1,
                                                    5'd12, 5'd2, 5'd31};
    localparam logic [4:0] SEG_QUOTA [SEGMENTS] = '{5'd4, 5'd2, 5'd16, 5'd0,
                                                    5'd3, 5'd1, 5'd31};
    localparam logic SEG_POLICY [SEGMENTS] = '{POLICY_MRU, POLICY_LIFO, POLICY_LIFO,
                                               POLICY_MRU, POLICY_MRU, POLICY_LIFO,
                                               POLICY_MRU};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                start;
    logic                busy;
    logic [PID_W-1:0]    process_id;
    logic [ADDR_W-1:0]   page_address;
    logic                is_done_marker;
    logic                result_valid;
    logic [2:0]          outcome;
    logic                evicted_valid;
    logic [ADDR_W-1:0]   evicted_address;
    logic [PID_W-1:0]    evicted_process;
    logic [31:0]         fault_count;
    logic [31:0]         replacement_count;

    // Shadow copy of the resident list, the counters and the registers.
    logic [ADDR_W-1:0]   shadow_page [FRAMES];
    logic [PID_W-1:0]    shadow_owner [FRAMES];
    int unsigned         shadow_resident;
    logic [31:0]         shadow_faults;
    logic [31:0]         shadow_repls;
    logic [4:0]          shadow_total;
    logic [4:0]          shadow_quota;
    logic                shadow_policy;

    // Results still owed by the block, oldest at ring_head.
    page_result_t        expected_ring [RING_DEPTH];
    int unsigned         ring_head = 0;
    int unsigned         ring_tail = 0;
    logic [ADDR_W-1:0]   address_pool [POOL_SIZE];
    int unsigned         mismatches = 0;

    page_frame_replacement uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .start             (start),
        .busy              (busy),
        .process_id        (process_id),
        .page_address      (page_address),
        .is_done_marker    (is_done_marker),
        .result_valid      (result_valid),
        .outcome           (outcome),
        .evicted_valid     (evicted_valid),
        .evicted_address   (evicted_address),
        .evicted_process   (evicted_process),
        .fault_count       (fault_count),
        .replacement_count (replacement_count)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] saturating_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Remove one entry, closing the gap by moving newer entries down.
    function automatic void drop_frame(int unsigned pos);
        int unsigned i;
        for (i = pos; i + 1 < shadow_resident; i++)
        begin
            shadow_page[i]  = shadow_page[i + 1];
            shadow_owner[i] = shadow_owner[i + 1];
        end
        if (shadow_resident > 0)
            shadow_resident--;
    endfunction

    function automatic void add_frame(logic [ADDR_W-1:0] page, logic [PID_W-1:0] owner);
        if (shadow_resident < FRAMES)
        begin
            shadow_page[shadow_resident]  = page;
            shadow_owner[shadow_resident] = owner;
            shadow_resident++;
        end
    endfunction

    // Works out the result of one request and moves the shadow state on.
    function automatic page_result_t resolve_request(page_req_t r);
        page_result_t      res;
        int unsigned       store_limit;
        int unsigned       owned;
        int unsigned       hit_pos;
        int unsigned       victim;
        int unsigned       i;
        bit                hit;
        bit                found;
        bit                quota_ok;
        bit                room_ok;
        logic [ADDR_W-1:0] moved_page;
        logic [PID_W-1:0]  moved_owner;
        res         = '0;
        res.outcome = OUT_DONE;
        store_limit = (shadow_total > FRAMES) ? FRAMES : shadow_total;
        owned       = 0;
        hit_pos     = 0;
        victim      = 0;
        hit         = 1'b0;
        found       = 1'b0;
        if (!r.done)
        begin
            for (i = 0; i < shadow_resident; i++)
            begin
                if (shadow_page[i] == r.addr)
                begin
                    hit     = 1'b1;
                    hit_pos = i;
                end
                if (shadow_owner[i] == r.pid)
                    owned++;
            end
            if (hit)
            begin
                res.outcome = OUT_HIT;
                if (shadow_policy == POLICY_MRU)
                begin
                    moved_page  = shadow_page[hit_pos];
                    moved_owner = shadow_owner[hit_pos];
                    drop_frame(hit_pos);
                    add_frame(moved_page, moved_owner);
                end
            end
            else
            begin
                quota_ok      = owned < shadow_quota;
                room_ok       = shadow_resident < store_limit;
                shadow_faults = saturating_inc(shadow_faults);
                if (quota_ok && room_ok)
                begin
                    add_frame(r.addr, r.pid);
                    res.outcome = OUT_LOADED;
                end
                else
                begin
                    shadow_repls = saturating_inc(shadow_repls);
                    if (quota_ok)
                    begin
                        // Only the global store is full: the newest entry goes.
                        if (shadow_resident > 0)
                        begin
                            found  = 1'b1;
                            victim = shadow_resident - 1;
                        end
                    end
                    else
                    begin
                        // Quota full: the newest entry of this process goes.
                        for (i = 0; i < shadow_resident; i++)
                        begin
                            if (shadow_owner[i] == r.pid)
                            begin
                                found  = 1'b1;
                                victim = i;
                            end
                        end
                    end
                    if (found)
                    begin
                        res.ev_valid = 1'b1;
                        res.ev_addr  = shadow_page[victim];
                        res.ev_pid   = shadow_owner[victim];
                        drop_frame(victim);
                        add_frame(r.addr, r.pid);
                        res.outcome = OUT_REPLACED;
                    end
                    else
                    begin
                        res.outcome = OUT_UNSERVED;
                    end
                end
            end
        end
        res.faults = shadow_faults;
        res.repls  = shadow_repls;
        return res;
    endfunction

    // Mostly requests over a small pool of pages and a few processes, so
    // that hits, quota evictions and full stores happen often; the rest are
    // done markers and requests with fully random fields.
    function automatic page_req_t make_random_request();
        page_req_t   r;
        int unsigned kind;
        kind   = $urandom_range(99);
        r.pid  = PID_W'($urandom_range(15));
        r.addr = ADDR_W'($urandom_range(16'hFFFF));
        r.done = 1'b0;
        if (kind < 8)
        begin
            r.done = 1'b1;
        end
        else if (kind < 80)
        begin
            if ($urandom_range(99) < 80)
                r.pid = PID_W'($urandom_range(3));
            r.addr = address_pool[$urandom_range(POOL_SIZE - 1)];
        end
        return r;
    endfunction

    // Waits until every request has its result back and the block is free.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (ring_tail != ring_head || busy !== 1'b0);
    endtask

    // Presents one request, holds it until the block takes it, then records
    // the result that the request should produce.
    task automatic issue(input page_req_t r, input bit use_known, input page_result_t known);
        page_result_t predicted;
        start          <= 1'b1;
        process_id     <= r.pid;
        page_address   <= r.addr;
        is_done_marker <= r.done;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = resolve_request(r);
        expected_ring[ring_tail % RING_DEPTH] = use_known ? known : predicted;
        ring_tail++;
    endtask

    // Writes one register while the block is idle, then reads it back.
    // The caller has already lowered start.
    task automatic program_register(input logic [1:0] index, input logic [4:0] value);
        logic [PDATA_W-1:0] stored;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (index)
            REG_TOTAL_FRAMES:    shadow_total  = value;
            REG_FRAMES_PER_PROC: shadow_quota  = value;
            default:             shadow_policy = value[0];
        endcase
        stored = (index == REG_POLICY) ? PDATA_W'(value[0]) : PDATA_W'(value);
        if (prdata !== stored)
        begin
            $error("register %0d: expected %0h, got %0h", index, stored, prdata);
            mismatches++;
        end
    endtask

    // Every result strobe is matched against the oldest outstanding request.
    always @(posedge clk)
    begin : check_result
        page_result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1)
        begin
            if (ring_tail == ring_head)
            begin
                $error("result with no request outstanding: outcome %0d", outcome);
                mismatches++;
            end
            else
            begin
                want = expected_ring[ring_head % RING_DEPTH];
                ring_head++;
                if (outcome !== want.outcome)
                begin
                    $error("outcome: expected %0d, got %0d", want.outcome, outcome);
                    mismatches++;
                end
                if (evicted_valid !== want.ev_valid)
                begin
                    $error("evicted_valid: expected %0d, got %0d", want.ev_valid,
                           evicted_valid);
                    mismatches++;
                end
                if (evicted_address !== want.ev_addr)
                begin
                    $error("evicted_address: expected %0h, got %0h", want.ev_addr,
                           evicted_address);
                    mismatches++;
                end
                if (evicted_process !== want.ev_pid)
                begin
                    $error("evicted_process: expected %0d, got %0d", want.ev_pid,
                           evicted_process);
                    mismatches++;
                end
                if (fault_count !== want.faults)
                begin
                    $error("fault_count: expected %0d, got %0d", want.faults, fault_count);
                    mismatches++;
                end
                if (replacement_count !== want.repls)
                begin
                    $error("replacement_count: expected %0d, got %0d", want.repls,
                           replacement_count);
                    mismatches++;
                end
            end
        end
    end

    // Ends the run if nothing is accepted on either side for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || result_valid === 1'b1)
                quiet = 0;
            else
                quiet++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned idle_pct;
        int unsigned seg;
        int unsigned n;
        int unsigned k;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        start          = 1'b0;
        process_id     = '0;
        page_address   = '0;
        is_done_marker = 1'b0;

        // Shadow state as it stands after reset.
        shadow_resident = 0;
        shadow_faults   = '0;
        shadow_repls    = '0;
        shadow_total    = TOTAL_FRAMES_RST;
        shadow_quota    = FRAMES_PER_PROC_RST;
        shadow_policy   = POLICY_RST;
        for (k = 0; k < FRAMES; k++)
        begin
            shadow_page[k]  = '0;
            shadow_owner[k] = '0;
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: each row may first reprogram a register, which is
        // only done once every earlier request has completed.
        for (k = 0; k < N_DIRECTED; k++)
        begin
            if (DIRECTED[k].cfg_en)
            begin
                start <= 1'b0;
                program_register(DIRECTED[k].cfg_reg, DIRECTED[k].cfg_val);
            end
            issue(DIRECTED[k].req, DIRECTED[k].typed, DIRECTED[k].known);
        end

        // Random part. The sender idles often in the first segments, very
        // often in the next ones and, but for an occasional drain, not at all in the last three; the list and
        // the counters carry over from one setting to the next, so lowered
        // frame counts meet a fuller list.
        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            start <= 1'b0;
            program_register(REG_TOTAL_FRAMES, SEG_TOTAL[seg]);
            program_register(REG_FRAMES_PER_PROC, SEG_QUOTA[seg]);
            program_register(REG_POLICY, {4'b0, SEG_POLICY[seg]});
            for (k = 0; k < POOL_SIZE; k++)
                address_pool[k] = ADDR_W'($urandom_range(16'hFFFF));
            idle_pct = (seg < 2) ? 34 : (seg < 4) ? 87 : 0;
            for (n = 0; n < SEGMENT_ITEMS; n++)
            begin
                issue(make_random_request(), 1'b0, NO_RESULT);
                if ($urandom_range(99) == 0)
                begin
                    // Now and then hold off until every result is back.
                    start <= 1'b0;
                    wait_idle();
                end
                else if ($urandom_range(99) < idle_pct)
                begin
                    start <= 1'b0;
                    do
                        @(posedge clk);
                    while ($urandom_range(99) < idle_pct);
                end
            end
        end

        start <= 1'b0;
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
